// ===== rtl/core/gasp_pkg.sv =====
// gasp_pkg: shared constants, status codes and structs of the glyph atlas shelf packer
// used by gasp_place and glyph_atlas_shelf_packer; depends on nothing
`timescale 1ns / 1ps

package gasp_pkg;

   // page limit and derived counter widths
   localparam int MAX_PAGES   = 16;
   localparam int PAGE_CNT_W  = $clog2(MAX_PAGES + 1);
   localparam int PAGE_IDX_W  = 4;

   // field widths
   localparam int GLYPH_W     = 12;
   localparam int ATLAS_W     = 13;
   localparam int CSR_IDX_W   = 1;

   // reset values of the page size registers
   localparam logic [ATLAS_W-1:0] ATLAS_WIDTH_RESET  = 13'd2048;
   localparam logic [ATLAS_W-1:0] ATLAS_HEIGHT_RESET = 13'd512;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_HEIGHT = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_CURRENT_PAGE = 2'd0,
      STATUS_NEW_PAGE     = 2'd1,
      STATUS_TOO_LARGE    = 2'd2,
      STATUS_PAGE_LIMIT   = 2'd3
   } status_type;

   // packing state carried between items
   typedef struct packed {
      logic [ATLAS_W-1:0]    cursor_x;
      logic [ATLAS_W-1:0]    cursor_y;
      logic [GLYPH_W-1:0]    row_height;
      logic [PAGE_CNT_W-1:0] pages_opened;
   } pack_state_type;

   // one placement result
   typedef struct packed {
      status_type            status;
      logic [PAGE_IDX_W-1:0] page_index;
      logic [GLYPH_W-1:0]    place_x;
      logic [GLYPH_W-1:0]    place_y;
   } place_result_type;

endpackage

// ===== rtl/core/gasp_place.sv =====
// gasp_place: one shelf placement pass over the current packing state
// depends on gasp_pkg
`timescale 1ns / 1ps

module gasp_place (
   input  gasp_pkg::pack_state_type      state,
   input  logic [gasp_pkg::ATLAS_W-1:0]  atlas_width,
   input  logic [gasp_pkg::ATLAS_W-1:0]  atlas_height,
   input  logic [gasp_pkg::GLYPH_W-1:0]  glyph_width,
   input  logic [gasp_pkg::GLYPH_W-1:0]  glyph_height,
   output gasp_pkg::pack_state_type      next_state,
   output gasp_pkg::place_result_type    result
);

   logic                               have_page;
   logic                               dims_ok;
   logic                               at_limit;
   logic [gasp_pkg::ATLAS_W:0]         x_end;
   logic [gasp_pkg::ATLAS_W:0]         y_end;
   logic                               x_over;
   logic                               y_over;
   logic [gasp_pkg::ATLAS_W+1:0]       row_next_y;
   logic [gasp_pkg::ATLAS_W+1:0]       wrap_y_end;
   logic                               wrap_ok;
   logic                               cur_fit;
   logic [gasp_pkg::ATLAS_W-1:0]       pos_x;
   logic [gasp_pkg::ATLAS_W-1:0]       pos_y;
   logic [gasp_pkg::GLYPH_W-1:0]       base_height;
   logic [gasp_pkg::ATLAS_W:0]         next_x;
   logic [gasp_pkg::PAGE_CNT_W-1:0]    page_last;

   // fit tests against the current row and the next row
   always_comb begin
      have_page  = (state.pages_opened != '0);
      dims_ok    = ({1'b0, glyph_width} < atlas_width) && ({1'b0, glyph_height} < atlas_height);
      at_limit   = (state.pages_opened >= gasp_pkg::PAGE_CNT_W'(gasp_pkg::MAX_PAGES));
      x_end      = {1'b0, state.cursor_x} + {2'b00, glyph_width};
      y_end      = {1'b0, state.cursor_y} + {2'b00, glyph_height};
      x_over     = (x_end >= {1'b0, atlas_width});
      y_over     = (y_end >= {1'b0, atlas_height});
      row_next_y = {2'b00, state.cursor_y} + {3'b000, state.row_height}
                   + (gasp_pkg::ATLAS_W+2)'(1);
      wrap_y_end = row_next_y + {3'b000, glyph_height};
      wrap_ok    = (wrap_y_end < {2'b00, atlas_height});
      // after a row change the width always fits, since it is below the page width
      cur_fit    = have_page && dims_ok && (x_over ? wrap_ok : !y_over);
   end

   // placement position and cursor update in the current page
   always_comb begin
      pos_x       = x_over ? '0 : state.cursor_x;
      pos_y       = x_over ? row_next_y[gasp_pkg::ATLAS_W-1:0] : state.cursor_y;
      base_height = x_over ? '0 : state.row_height;
      next_x      = {1'b0, pos_x} + {2'b00, glyph_width} + (gasp_pkg::ATLAS_W+1)'(1);
      page_last   = state.pages_opened - gasp_pkg::PAGE_CNT_W'(1);
   end

   // choose between current page, new page and the error cases
   always_comb begin
      next_state        = state;
      result.status     = gasp_pkg::STATUS_PAGE_LIMIT;
      result.page_index = '0;
      result.place_x    = '0;
      result.place_y    = '0;
      if (cur_fit) begin
         result.status         = gasp_pkg::STATUS_CURRENT_PAGE;
         result.page_index     = gasp_pkg::PAGE_IDX_W'(page_last);
         result.place_x        = pos_x[gasp_pkg::GLYPH_W-1:0];
         result.place_y        = pos_y[gasp_pkg::GLYPH_W-1:0];
         next_state.cursor_x   = next_x[gasp_pkg::ATLAS_W-1:0];
         next_state.cursor_y   = pos_y;
         next_state.row_height = (glyph_height > base_height) ? glyph_height : base_height;
      end else if (!at_limit) begin
         // open a fresh page, counted even when the rectangle is too large
         next_state.pages_opened = state.pages_opened + gasp_pkg::PAGE_CNT_W'(1);
         next_state.cursor_y     = '0;
         if (dims_ok) begin
            result.status         = gasp_pkg::STATUS_NEW_PAGE;
            result.page_index     = gasp_pkg::PAGE_IDX_W'(state.pages_opened);
            next_state.cursor_x   = {1'b0, glyph_width} + gasp_pkg::ATLAS_W'(1);
            next_state.row_height = glyph_height;
         end else begin
            result.status         = gasp_pkg::STATUS_TOO_LARGE;
            next_state.cursor_x   = '0;
            next_state.row_height = '0;
         end
      end
   end

endmodule

// ===== rtl/core/glyph_atlas_shelf_packer.sv =====
// glyph_atlas_shelf_packer: top level with input register, packing state and result register
// depends on gasp_pkg and gasp_place
`timescale 1ns / 1ps

// Places glyph rectangles into atlas pages by row-shelf packing with a one-pixel gap
// between rectangles and between rows. Each request item gives one response item with
// a status, the page index and the top-left corner. An accepted item goes through the
// input register, then the result register; a new item is taken every cycle while
// rsp_stall is low: the placement is a single pass of adds and compares on the
// registered cursor state, which is updated as the item moves into the result register.
// Page size is set through csr_index 0 (width) and 1 (height); write it only while idle.
module glyph_atlas_shelf_packer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [gasp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gasp_pkg::ATLAS_W-1:0]        csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [gasp_pkg::GLYPH_W-1:0]        req_glyph_width,
   input  logic [gasp_pkg::GLYPH_W-1:0]        req_glyph_height,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [gasp_pkg::PAGE_IDX_W-1:0]     rsp_page_index,
   output logic [gasp_pkg::GLYPH_W-1:0]        rsp_place_x,
   output logic [gasp_pkg::GLYPH_W-1:0]        rsp_place_y
);

   logic [gasp_pkg::ATLAS_W-1:0]  atlas_width_ff;
   logic [gasp_pkg::ATLAS_W-1:0]  atlas_height_ff;
   logic                          in_valid_ff;
   logic [gasp_pkg::GLYPH_W-1:0]  in_width_ff;
   logic [gasp_pkg::GLYPH_W-1:0]  in_height_ff;
   gasp_pkg::pack_state_type      state_ff;
   gasp_pkg::pack_state_type      state_in;
   logic                          rsp_valid_ff;
   gasp_pkg::place_result_type    result_ff;
   gasp_pkg::place_result_type    result_in;
   logic                          in_adv;
   logic                          req_take;

   // handshake: the input register moves on when the result register is free or drained
   assign in_adv    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !in_adv;
   assign req_take  = req_valid && !req_stall;

   // page size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         atlas_width_ff  <= gasp_pkg::ATLAS_WIDTH_RESET;
         atlas_height_ff <= gasp_pkg::ATLAS_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            gasp_pkg::CSR_ATLAS_WIDTH:  atlas_width_ff  <= csr_write_data;
            gasp_pkg::CSR_ATLAS_HEIGHT: atlas_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (in_adv) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_width_ff  <= req_glyph_width;
         in_height_ff <= req_glyph_height;
      end
   end

   // placement pass
   gasp_place u_place (
      .state        (state_ff),
      .atlas_width  (atlas_width_ff),
      .atlas_height (atlas_height_ff),
      .glyph_width  (in_width_ff),
      .glyph_height (in_height_ff),
      .next_state   (state_in),
      .result       (result_in)
   );

   // packing state, updated once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (in_adv) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = result_ff.status;
   assign rsp_page_index = result_ff.page_index;
   assign rsp_place_x    = result_ff.place_x;
   assign rsp_place_y    = result_ff.place_y;

   // page count stays within the limit
   a_page_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.pages_opened <= gasp_pkg::PAGE_CNT_W'(gasp_pkg::MAX_PAGES))
      else $error("page count beyond limit");

   // error results carry no position
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (result_ff.status == gasp_pkg::STATUS_TOO_LARGE ||
                        result_ff.status == gasp_pkg::STATUS_PAGE_LIMIT))
      |-> (result_ff.page_index == '0 && result_ff.place_x == '0 && result_ff.place_y == '0))
      else $error("error result with nonzero position");

   // a page limit item leaves the state untouched
   a_limit_hold: assert property (@(posedge clock) disable iff (reset)
      (in_adv && result_in.status == gasp_pkg::STATUS_PAGE_LIMIT) |=> $stable(state_ff))
      else $error("state changed on page limit");

   // an item leaving the input register shows up as a response
   a_adv_valid: assert property (@(posedge clock) disable iff (reset)
      in_adv |=> rsp_valid_ff)
      else $error("advanced item lost");

endmodule

// ===== test/tb_glyph_atlas_shelf_packer.sv =====
// tb_glyph_atlas_shelf_packer: self-checking bench for the glyph atlas shelf packer
// sends glyph items and page size writes, predicts every placement and checks each result
// depends on gasp_pkg and glyph_atlas_shelf_packer
`timescale 1ns / 1ps

module tb_glyph_atlas_shelf_packer;

   // block ports, all inputs known from time zero
   logic                             clock            = 1'b0;
   logic                             reset            = 1'b1;
   logic                             csr_write_enable = 1'b0;
   logic [gasp_pkg::CSR_IDX_W-1:0]   csr_index        = gasp_pkg::CSR_ATLAS_WIDTH;
   logic [gasp_pkg::ATLAS_W-1:0]     csr_write_data   = '0;
   logic                             req_valid        = 1'b0;
   logic                             req_stall;
   logic [gasp_pkg::GLYPH_W-1:0]     req_glyph_width  = '0;
   logic [gasp_pkg::GLYPH_W-1:0]     req_glyph_height = '0;
   logic                             rsp_valid;
   logic                             rsp_stall        = 1'b0;
   logic [1:0]                       rsp_status;
   logic [gasp_pkg::PAGE_IDX_W-1:0]  rsp_page_index;
   logic [gasp_pkg::GLYPH_W-1:0]     rsp_place_x;
   logic [gasp_pkg::GLYPH_W-1:0]     rsp_place_y;

   // packer image: page size, cursor state and placements still to come
   logic [gasp_pkg::ATLAS_W-1:0]     page_width  = gasp_pkg::ATLAS_WIDTH_RESET;
   logic [gasp_pkg::ATLAS_W-1:0]     page_height = gasp_pkg::ATLAS_HEIGHT_RESET;
   gasp_pkg::pack_state_type         shelf       = '0;
   gasp_pkg::place_result_type       placement_queue[$];
   int                               mismatch_count = 0;
   int                               rsp_hold       = 0;
   bit                               no_idle        = 1'b0;

   glyph_atlas_shelf_packer uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_glyph_width  (req_glyph_width),
      .req_glyph_height (req_glyph_height),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_page_index   (rsp_page_index),
      .rsp_place_x      (rsp_place_x),
      .rsp_place_y      (rsp_place_y)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // idle cycles before an item, zero during no-idle stretches
   function automatic int draw_wait();
      return no_idle ? 0 : int'($urandom_range(0, 19));
   endfunction

   // try the current page; a row change is kept once taken
   function automatic bit shelf_try(input logic [gasp_pkg::GLYPH_W-1:0] w,
                                    input logic [gasp_pkg::GLYPH_W-1:0] h,
                                    output logic [gasp_pkg::ATLAS_W-1:0] px,
                                    output logic [gasp_pkg::ATLAS_W-1:0] py);
      int unsigned aw, ah;
      aw = {19'd0, page_width};
      ah = {19'd0, page_height};
      px = '0;
      py = '0;
      if (w >= aw || h >= ah) return 1'b0;
      // overrun of the row moves to a new row when that row has room
      if (shelf.cursor_x + w >= aw && shelf.cursor_y + shelf.row_height + h + 1 < ah) begin
         shelf.cursor_y   = gasp_pkg::ATLAS_W'(shelf.cursor_y + shelf.row_height + 1);
         shelf.cursor_x   = '0;
         shelf.row_height = '0;
      end
      if (shelf.cursor_x + w >= aw || shelf.cursor_y + h >= ah) return 1'b0;
      px = shelf.cursor_x;
      py = shelf.cursor_y;
      shelf.cursor_x = gasp_pkg::ATLAS_W'(shelf.cursor_x + w + 1);
      if (h > shelf.row_height) shelf.row_height = h;
      return 1'b1;
   endfunction

   // expected placement of one glyph, advancing the packer image
   function automatic gasp_pkg::place_result_type predict_placement(
         input logic [gasp_pkg::GLYPH_W-1:0] w,
         input logic [gasp_pkg::GLYPH_W-1:0] h);
      gasp_pkg::place_result_type    r;
      logic [gasp_pkg::ATLAS_W-1:0]  px, py;
      r  = '0;
      px = '0;
      py = '0;
      if (shelf.pages_opened > 0 && shelf_try(w, h, px, py)) begin
         r.status     = gasp_pkg::STATUS_CURRENT_PAGE;
         r.page_index = gasp_pkg::PAGE_IDX_W'(shelf.pages_opened - 1'b1);
      end else if (shelf.pages_opened >= gasp_pkg::MAX_PAGES) begin
         r.status = gasp_pkg::STATUS_PAGE_LIMIT;
      end else begin
         // fresh page from the origin, counted even if the glyph cannot fit
         shelf.pages_opened = shelf.pages_opened + 1'b1;
         shelf.cursor_x     = '0;
         shelf.cursor_y     = '0;
         shelf.row_height   = '0;
         if (shelf_try(w, h, px, py)) begin
            r.status     = gasp_pkg::STATUS_NEW_PAGE;
            r.page_index = gasp_pkg::PAGE_IDX_W'(shelf.pages_opened - 1'b1);
         end else begin
            r.status = gasp_pkg::STATUS_TOO_LARGE;
         end
      end
      if (r.status == gasp_pkg::STATUS_CURRENT_PAGE || r.status == gasp_pkg::STATUS_NEW_PAGE)
      begin
         r.place_x = px[gasp_pkg::GLYPH_W-1:0];
         r.place_y = py[gasp_pkg::GLYPH_W-1:0];
      end else begin
         r.page_index = '0;
      end
      return r;
   endfunction

   // glyph dimension: mostly small for the page, some exact fits, some anything
   function automatic logic [gasp_pkg::GLYPH_W-1:0] draw_dim(input int span, input int used);
      int pick, dim, hi;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         dim = $urandom_range(0, 4095);
      end else if (pick < 10) begin
         // fills what is left of the row or column, or just misses
         dim = $urandom_range(0, 2);
         dim = span - used - dim;
      end else if (pick < 13) begin
         dim = $urandom_range(0, 2);
         dim = span - dim;
      end else begin
         hi = span / 8;
         if (hi < 1) hi = 1;
         if (hi > 4095) hi = 4095;
         dim = $urandom_range(0, hi);
      end
      if (dim < 0) dim = 0;
      if (dim > 4095) dim = 4095;
      return dim[gasp_pkg::GLYPH_W-1:0];
   endfunction

   // send one glyph item and record its expected placement on acceptance
   task automatic send_glyph(input logic [gasp_pkg::GLYPH_W-1:0] w,
                             input logic [gasp_pkg::GLYPH_W-1:0] h);
      int                         gap;
      gasp_pkg::place_result_type expected;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_glyph_width  <= w;
      req_glyph_height <= h;
      do @(posedge clock); while (req_stall);
      expected = predict_placement(w, h);
      placement_queue.insert(placement_queue.size(), expected);
   endtask

   // hold off the sender until every placement is back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (placement_queue.size() != 0);
   endtask

   // page size writes, only with the block idle
   task automatic set_page_size(input logic [gasp_pkg::ATLAS_W-1:0] w,
                                input logic [gasp_pkg::ATLAS_W-1:0] h);
      wait_for_results();
      repeat (3) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= gasp_pkg::CSR_ATLAS_WIDTH;
      csr_write_data   <= w;
      @(posedge clock);
      csr_index        <= gasp_pkg::CSR_ATLAS_HEIGHT;
      csr_write_data   <= h;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      page_width  = w;
      page_height = h;
   endtask

   // random glyph stream on one page size, ending early once enough pages are open
   task automatic run_random_packing(input int w, input int h, input int count,
                                     input int page_goal);
      set_page_size(gasp_pkg::ATLAS_W'(w), gasp_pkg::ATLAS_W'(h));
      for (int n = 0; n < count && shelf.pages_opened < page_goal; n++) begin
         if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 2) wait_for_results();
         send_glyph(draw_dim(int'(page_width), int'(shelf.cursor_x)),
                    draw_dim(int'(page_height), int'(shelf.cursor_y)));
      end
   endtask

   // first request, field extremes, width and height bounds, row change, page overflow
   task automatic test_first_page_and_rows();
      send_glyph(12'd0, 12'd0);
      send_glyph(12'd4095, 12'd4095);
      send_glyph(12'd2047, 12'd0);
      send_glyph(12'd2046, 12'd510);
      send_glyph(12'd0, 12'd0);
      send_glyph(12'd0, 12'd0);
      send_glyph(12'd5, 12'd0);
      send_glyph(12'd0, 12'd1);
      send_glyph(12'd1000, 12'd20);
      send_glyph(12'd1000, 12'd30);
      send_glyph(12'd1000, 12'd5);
   endtask

   // shrink the page under a cursor that now lies outside it
   task automatic test_resize_mid_page();
      set_page_size(13'd500, 13'd40);
      send_glyph(12'd10, 12'd3);
      send_glyph(12'd488, 12'd30);
      send_glyph(12'd499, 12'd39);
   endtask

   // one-pixel page, then zero-sized page where everything is too large
   task automatic test_degenerate_pages();
      set_page_size(13'd1, 13'd1);
      send_glyph(12'd0, 12'd0);
      send_glyph(12'd0, 12'd0);
      send_glyph(12'd1, 12'd0);
      send_glyph(12'd0, 12'd1);
      set_page_size(13'd0, 13'd0);
      send_glyph(12'd0, 12'd0);
   endtask

   // random packing over several page sizes while pages remain
   task automatic test_random_packing();
      run_random_packing($urandom_range(8, 64), $urandom_range(8, 64), 150, 12);
      run_random_packing(4096, 4096, 200, gasp_pkg::MAX_PAGES + 1);
      run_random_packing($urandom_range(32, 1024), $urandom_range(32, 1024), 100,
                         gasp_pkg::MAX_PAGES + 1);
      run_random_packing(8191, 8191, 150, gasp_pkg::MAX_PAGES + 1);
   endtask

   // run into the page limit, then keep packing the last page
   task automatic test_page_limit();
      run_random_packing($urandom_range(8, 64), $urandom_range(8, 64), 300,
                         gasp_pkg::MAX_PAGES);
      run_random_packing($urandom_range(8, 64), $urandom_range(8, 64), 20,
                         gasp_pkg::MAX_PAGES + 1);
      run_random_packing(8191, 8191, 80, gasp_pkg::MAX_PAGES + 1);
      run_random_packing($urandom_range(64, 4096), $urandom_range(64, 4096), 60,
                         gasp_pkg::MAX_PAGES + 1);
      run_random_packing(0, 0, 5, gasp_pkg::MAX_PAGES + 1);
      run_random_packing(1, 1, 5, gasp_pkg::MAX_PAGES + 1);
   endtask

   // result side: random stall per item, compare against the oldest expectation
   always @(posedge clock) begin
      gasp_pkg::place_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (placement_queue.size() == 0) begin
               $error("unexpected result: status %0d page %0d x %0d y %0d",
                      rsp_status, rsp_page_index, rsp_place_x, rsp_place_y);
               mismatch_count++;
            end else begin
               want = placement_queue.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_page_index !== want.page_index) begin
                  $error("page_index: expected %0d, got %0d", want.page_index, rsp_page_index);
                  mismatch_count++;
               end
               if (rsp_place_x !== want.place_x) begin
                  $error("place_x: expected %0d, got %0d", want.place_x, rsp_place_x);
                  mismatch_count++;
               end
               if (rsp_place_y !== want.place_y) begin
                  $error("place_y: expected %0d, got %0d", want.place_y, rsp_place_y);
                  mismatch_count++;
               end
            end
            rsp_hold = draw_wait();
         end else if (rsp_hold > 0) begin
            rsp_hold = rsp_hold - 1;
         end
         rsp_stall <= (rsp_hold > 0);
      end
   end

   // test sequence
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_first_page_and_rows();
      test_resize_mid_page();
      test_degenerate_pages();
      test_random_packing();
      test_page_limit();
      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS glyph_atlas_shelf_packer");
      end else begin
         $display("FAIL glyph_atlas_shelf_packer");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("FAIL glyph_atlas_shelf_packer");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/gasp_pkg.sv
rtl/core/gasp_place.sv
rtl/core/glyph_atlas_shelf_packer.sv
test/tb_glyph_atlas_shelf_packer.sv
